// ===== hw/rtl/lhc_pkg.sv =====
// ----------------------------------------------------------------------------
// lhc_pkg
// Shared types and constants of the lattice hint compute core.
// ----------------------------------------------------------------------------
package lhc_pkg;

	// field widths
	localparam int unsigned COEFF_W  = 24;
	localparam int unsigned W1_W     = 12;
	localparam int unsigned HINT_W   = 13;
	localparam int unsigned WORD_W   = 32;
	localparam int unsigned Q_W      = 17;
	localparam int unsigned ALPHA_W  = 13;
	localparam int unsigned GAMMA_W  = 17;
	localparam int unsigned MULT_W   = 32;
	localparam int unsigned SHIFT_W  = 6;
	localparam int unsigned PROD_W   = 2 * WORD_W;

	// stream widths
	localparam int unsigned IN_DATA_W  = 112;
	localparam int unsigned IN_USER_W  = 2;
	localparam int unsigned OUT_DATA_W = 16;

	// configuration port
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_MODULUS_Q   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HINT_ALPHA  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAMMA_TWO   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BARRETT_MUL = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BARRETT_SHR = 3'd4;

	// reset values
	localparam logic [Q_W-1:0]     RST_MODULUS_Q   = 17'd119297;
	localparam logic [ALPHA_W-1:0] RST_HINT_ALPHA  = 13'd4096;
	localparam logic [GAMMA_W-1:0] RST_GAMMA_TWO   = 17'd2;
	localparam logic [MULT_W-1:0]  RST_BARRETT_MUL = 32'd0;
	localparam logic [SHIFT_W-1:0] RST_BARRETT_SHR = 6'd32;

	// configuration registers as seen by the datapath
	typedef struct packed {
		logic [Q_W-1:0]     modulus_q;
		logic [ALPHA_W-1:0] hint_alpha;
		logic [GAMMA_W-1:0] gamma_two;
		logic [MULT_W-1:0]  barrett_multiplier;
		logic [SHIFT_W-1:0] barrett_shift;
	} lhc_cfg_t;

	// one input coefficient set
	typedef struct packed {
		logic signed [COEFF_W-1:0] w_coeff;
		logic signed [COEFF_W-1:0] z2_coeff;
		logic signed [COEFF_W-1:0] challenge_coeff;
		logic signed [COEFF_W-1:0] b0c_coeff;
		logic [W1_W-1:0]           w1_coeff;
		logic                      first_row;
		logic                      bit_b;
	} lhc_item_t;

endpackage

// ===== hw/rtl/lhc_prep.sv =====
// ----------------------------------------------------------------------------
// lhc_prep
// Forms w_hat, lifts a negative value by q and adds the rounding offset.
// ----------------------------------------------------------------------------
module lhc_prep (
	input  lhc_pkg::lhc_item_t          item,
	input  lhc_pkg::lhc_cfg_t           cfg,
	output logic [lhc_pkg::WORD_W-1:0]  v
);
	import lhc_pkg::*;

	logic [WORD_W-1:0] w_ext;
	logic [WORD_W-1:0] z2_ext;
	logic [WORD_W-1:0] c_ext;
	logic [WORD_W-1:0] b0c_ext;
	logic [WORD_W-1:0] c_add;
	logic [WORD_W-1:0] w_hat;
	logic [WORD_W-1:0] lift;
	logic [WORD_W-1:0] half_gamma;

	// sign extend the coefficients to the 32-bit word
	assign w_ext   = {{(WORD_W-COEFF_W){item.w_coeff[COEFF_W-1]}}, item.w_coeff};
	assign z2_ext  = {{(WORD_W-COEFF_W){item.z2_coeff[COEFF_W-1]}}, item.z2_coeff};
	assign c_ext   = {{(WORD_W-COEFF_W){item.challenge_coeff[COEFF_W-1]}},
		item.challenge_coeff};
	assign b0c_ext = {{(WORD_W-COEFF_W){item.b0c_coeff[COEFF_W-1]}}, item.b0c_coeff};

	// challenge only on row zero with the flag clear
	assign c_add = (item.first_row && !item.bit_b) ? c_ext : '0;

	assign w_hat = w_ext - z2_ext + c_add + b0c_ext;

	// lift negative values by the modulus
	assign lift = w_hat[WORD_W-1] ? {{(WORD_W-Q_W){1'b0}}, cfg.modulus_q} : '0;

	// rounding offset gamma2 / 2
	assign half_gamma = {{(WORD_W-GAMMA_W+1){1'b0}}, cfg.gamma_two[GAMMA_W-1:1]};

	assign v = w_hat + lift + half_gamma;

endmodule

// ===== hw/rtl/lhc_shift.sv =====
// ----------------------------------------------------------------------------
// lhc_shift
// Barrett quotient: right shift of the 64-bit product, low word kept.
// ----------------------------------------------------------------------------
module lhc_shift (
	input  logic [lhc_pkg::PROD_W-1:0]  prod,
	input  lhc_pkg::lhc_cfg_t           cfg,
	output logic [lhc_pkg::WORD_W-1:0]  hb
);
	import lhc_pkg::*;

	logic [PROD_W-1:0] shifted;

	// barrel shift by the programmed amount
	assign shifted = prod >> cfg.barrett_shift;
	assign hb      = shifted[WORD_W-1:0];

endmodule

// ===== hw/rtl/lhc_fin.sv =====
// ----------------------------------------------------------------------------
// lhc_fin
// Folds the high part into range and centres w1 minus it modulo alpha.
// ----------------------------------------------------------------------------
module lhc_fin (
	input  logic [lhc_pkg::WORD_W-1:0]  hb,
	input  logic [lhc_pkg::W1_W-1:0]    w1,
	input  lhc_pkg::lhc_cfg_t           cfg,
	output logic [lhc_pkg::HINT_W-1:0]  hint
);
	import lhc_pkg::*;

	logic [WORD_W-1:0] alpha;
	logic [WORD_W-1:0] half_alpha;
	logic [WORD_W-1:0] over_diff;
	logic [WORD_W-1:0] hb_fold;
	logic [WORD_W-1:0] h_raw;
	logic [WORD_W-1:0] h_pos;
	logic [WORD_W-1:0] cent_diff;
	logic [WORD_W-1:0] h_cent;

	assign alpha      = {{(WORD_W-ALPHA_W){1'b0}}, cfg.hint_alpha};
	assign half_alpha = {{(WORD_W-ALPHA_W+1){1'b0}}, cfg.hint_alpha[ALPHA_W-1:1]};

	// high part at or above alpha wraps back by alpha
	assign over_diff = alpha - (hb + 32'd1);
	assign hb_fold   = over_diff[WORD_W-1] ? (hb - alpha) : hb;

	// difference lifted into the positive range
	assign h_raw = {{(WORD_W-W1_W){1'b0}}, w1} - hb_fold;
	assign h_pos = h_raw[WORD_W-1] ? (h_raw + alpha) : h_raw;

	// values above alpha / 2 move to the negative side
	assign cent_diff = half_alpha - h_pos;
	assign h_cent    = cent_diff[WORD_W-1] ? (h_pos - alpha) : h_pos;

	assign hint = h_cent[HINT_W-1:0];

endmodule

// ===== hw/rtl/lattice_hint_compute_core.sv =====
// ----------------------------------------------------------------------------
// lattice_hint_compute_core
// Per-coefficient hint maker with a programmable Barrett decomposition.
// ----------------------------------------------------------------------------
// Usage:
//  - s_axis carries one coefficient set per transaction; m_axis returns one
//    13-bit centred hint per accepted set, in order.
//  - cfg_* writes the five decomposition registers; cfg_ready is always high.
//    Write them only while no transaction is in flight.
//  - five register stages: input, prepare, 32x32 product, shift, result.
//    An accepted transaction's hint is valid once it reaches the result stage.
//  - throughput is one transaction per cycle; the single pipelined multiplier
//    sets the stage boundary; while m_axis_tready is high every stage takes
//    a new item each cycle. Else the pipeline fills up and then drops
//    s_axis_tready; a stage moves on as soon as the one after it frees.
//  - arst_n clears all valid flags and loads the register reset values
//    (modulus 119297, alpha 4096, gamma2 2, multiplier 0, shift 32).
// ----------------------------------------------------------------------------
module lattice_hint_compute_core (
	input  logic                            clk,
	input  logic                            arst_n,
	// w_coeff[23:0], z2_coeff[47:24], challenge_coeff[71:48],
	// b0c_coeff[95:72], w1_coeff[107:96], zero[111:108]
	input  logic [lhc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// first_row[0], bit_b[1]
	input  logic [lhc_pkg::IN_USER_W-1:0]   s_axis_tuser,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// hint_value[12:0], zero[15:13]
	output logic [lhc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lhc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lhc_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import lhc_pkg::*;

	lhc_cfg_t          cfg_q;
	lhc_item_t         item_in;
	lhc_item_t         item_s1;
	logic              vld_s1;
	logic              vld_s2;
	logic              vld_s3;
	logic              vld_s4;
	logic              vld_s5;
	logic              rdy_s1;
	logic              rdy_s2;
	logic              rdy_s3;
	logic              rdy_s4;
	logic              rdy_s5;
	logic [WORD_W-1:0] v_comb;
	logic [WORD_W-1:0] v_s2;
	logic [W1_W-1:0]   w1_s2;
	logic [PROD_W-1:0] prod_s3;
	logic [W1_W-1:0]   w1_s3;
	logic [WORD_W-1:0] hb_comb;
	logic [WORD_W-1:0] hb_s4;
	logic [W1_W-1:0]   w1_s4;
	logic [HINT_W-1:0] hint_comb;
	logic [HINT_W-1:0] hint_s5;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.modulus_q          <= RST_MODULUS_Q;
			cfg_q.hint_alpha         <= RST_HINT_ALPHA;
			cfg_q.gamma_two          <= RST_GAMMA_TWO;
			cfg_q.barrett_multiplier <= RST_BARRETT_MUL;
			cfg_q.barrett_shift      <= RST_BARRETT_SHR;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MODULUS_Q:   cfg_q.modulus_q          <= cfg_data[Q_W-1:0];
				REG_HINT_ALPHA:  cfg_q.hint_alpha         <= cfg_data[ALPHA_W-1:0];
				REG_GAMMA_TWO:   cfg_q.gamma_two          <= cfg_data[GAMMA_W-1:0];
				REG_BARRETT_MUL: cfg_q.barrett_multiplier <= cfg_data[MULT_W-1:0];
				REG_BARRETT_SHR: cfg_q.barrett_shift      <= cfg_data[SHIFT_W-1:0];
				default: ;
			endcase
		end
	end

	// unpack the input transaction
	assign item_in.w_coeff         = s_axis_tdata[23:0];
	assign item_in.z2_coeff        = s_axis_tdata[47:24];
	assign item_in.challenge_coeff = s_axis_tdata[71:48];
	assign item_in.b0c_coeff       = s_axis_tdata[95:72];
	assign item_in.w1_coeff        = s_axis_tdata[107:96];
	assign item_in.first_row       = s_axis_tuser[0];
	assign item_in.bit_b           = s_axis_tuser[1];

	// stage may load when empty or when the next stage takes its item
	assign rdy_s5 = !vld_s5 || m_axis_tready;
	assign rdy_s4 = !vld_s4 || rdy_s5;
	assign rdy_s3 = !vld_s3 || rdy_s4;
	assign rdy_s2 = !vld_s2 || rdy_s3;
	assign rdy_s1 = !vld_s1 || rdy_s2;

	assign s_axis_tready = rdy_s1;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= s_axis_tvalid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_s4) vld_s4 <= vld_s3;
			if (rdy_s5) vld_s5 <= vld_s4;
		end
	end

	// datapath logic between stages
	lhc_prep u_prep (
		.item (item_s1),
		.cfg  (cfg_q),
		.v    (v_comb)
	);

	lhc_shift u_shift (
		.prod (prod_s3),
		.cfg  (cfg_q),
		.hb   (hb_comb)
	);

	lhc_fin u_fin (
		.hb   (hb_s4),
		.w1   (w1_s4),
		.cfg  (cfg_q),
		.hint (hint_comb)
	);

	// payload registers
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			item_s1 <= item_in;
		end
		if (rdy_s2) begin
			v_s2  <= v_comb;
			w1_s2 <= item_s1.w1_coeff;
		end
		if (rdy_s3) begin
			prod_s3 <= PROD_W'(v_s2) * PROD_W'(cfg_q.barrett_multiplier);
			w1_s3   <= w1_s2;
		end
		if (rdy_s4) begin
			hb_s4 <= hb_comb;
			w1_s4 <= w1_s3;
		end
		if (rdy_s5) begin
			hint_s5 <= hint_comb;
		end
	end

	assign m_axis_tvalid = vld_s5;
	assign m_axis_tdata  = {{(OUT_DATA_W-HINT_W){1'b0}}, hint_s5};

	// an item leaving stage four lands in the result stage
	a_fwd_result: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s4 && rdy_s5) |=> vld_s5)
		else $error("item lost between shift and result stage");

	// input stalls only when every stage holds an item
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (vld_s1 && vld_s2 && vld_s3 && vld_s4 && vld_s5))
		else $error("input stalled with a free stage");

	// an accepting receiver keeps the input open
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input stalled while output drains");

endmodule
